### hdl/urt_pkg.sv
// urt_pkg: shared types and codes for the unacked retransmit tracker
// holds the channel payload structs, event and action codes, register indexes
// and the control bundle that the top level hands to each list cell
package urt_pkg;

  localparam int SEQ_W    = 16;
  localparam int THRESH_W = 7;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  // event codes
  localparam logic [1:0] MODE_SEND    = 2'd0;
  localparam logic [1:0] MODE_ACK     = 2'd1;
  localparam logic [1:0] MODE_TIMEOUT = 2'd2;

  // result action codes
  localparam logic [2:0] ACT_SEND    = 3'd0;
  localparam logic [2:0] ACT_RETX    = 3'd1;
  localparam logic [2:0] ACT_REARM   = 3'd2;
  localparam logic [2:0] ACT_ACK     = 3'd3;
  localparam logic [2:0] ACT_REFUSED = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRAIN   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RUNNING = 8'd3;

  // register reset values
  localparam logic [SEQ_W-1:0]    TOTAL_RST = 16'd0;
  localparam logic [THRESH_W-1:0] NEAR_RST  = 7'd5;
  localparam logic [THRESH_W-1:0] DRAIN_RST = 7'd20;

  typedef struct packed {
    logic [1:0]       mode;
    logic [SEQ_W-1:0] seq;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       action;
    logic [SEQ_W-1:0] out_seq;
    logic             arm_timer;
    logic             more_to_send;
    logic             list_empty;
    logic             list_full;
  } out_item_t;

  // broadcast to every cell of the list
  typedef struct packed {
    logic                load;
    logic                shift;
    logic [SEQ_W-1:0]    key;
    logic [SEQ_W-1:0]    load_val;
    logic [THRESH_W-1:0] thresh;
  } cell_ctl_t;

endpackage

### hdl/urt_cell.sv
// urt_cell: one entry of the unacked sequence list
// compares its entry against the broadcast key, loads on append and takes its
// right neighbor's entry when the list closes a gap; uses urt_pkg
module urt_cell
  import urt_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [CW-1:0]    count,
  input  logic [SEQ_W-1:0] right_entry,
  output logic [SEQ_W-1:0] entry,
  output logic             match,
  output logic             below_thresh
);

  localparam int TW = (CW > THRESH_W) ? CW : THRESH_W;

  logic [SEQ_W-1:0] entry_r;
  logic [SEQ_W-1:0] entry_nxt;
  logic             occupied;
  logic             at_or_above;
  logic [TW-1:0]    idx_ext;
  logic [TW-1:0]    th_ext;

  assign idx_ext     = TW'(IDX);
  assign th_ext      = TW'(ctl.thresh);
  assign occupied    = CW'(IDX) < count;
  assign match       = occupied && (entry_r == ctl.key);
  // the list is in ascending order, so every entry from the hit onward is >= key
  assign at_or_above = occupied && (entry_r >= ctl.key);
  assign below_thresh = match && (idx_ext < th_ext);
  assign entry       = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load && (CW'(IDX) == count)) begin
      entry_nxt = ctl.load_val;
    end else if (ctl.shift && at_or_above) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

### hdl/unacked_retransmit_tracker.sv
// unacked_retransmit_tracker: top level of the sender-side unacked list tracker
// instantiates a row of urt_cell entries; uses urt_pkg
//
// Tracks sequence numbers that were sent but not yet acknowledged, oldest first,
// in a row of LIST_DEPTH cells. Each event is first captured in the input
// holding register; then all cells compare against the key in parallel, shift
// toward the head to close the gap of an ack, and the result is written to the
// output register. The next event is taken in the cycle after the result is
// produced, while the result may still wait on out_stall. Unknown acks, unknown
// timeout checks and mode 3 give no result. The list starts empty after reset
// with no clearing pass; cfg_ready is always high. Registers are to be written
// only while no event is in flight; the block itself does not enforce it.
module unacked_retransmit_tracker
  import urt_pkg::*;
#(
  parameter int LIST_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int CW = $clog2(LIST_DEPTH + 1);

  // configuration
  logic [SEQ_W-1:0]    total_r;
  logic [THRESH_W-1:0] near_r;
  logic [THRESH_W-1:0] drain_r;
  logic                running_r;

  // event holding register
  logic     hold_valid_r;
  in_item_t hold_r;

  // bookkeeping
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic [SEQ_W-1:0] sent_r;
  logic [SEQ_W-1:0] sent_nxt;

  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_r;
  out_item_t out_nxt;

  cell_ctl_t        ctl;
  logic [SEQ_W-1:0] entry_w [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] match_vec;
  logic [LIST_DEPTH-1:0] below_vec;

  logic          exec;
  logic          hit;
  logic          all_sent;
  logic          list_full;
  logic          can_send;
  logic [SEQ_W:0] sent_inc;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] count_dec;

  assign cfg_ready = 1'b1;
  assign in_stall  = hold_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign exec      = hold_valid_r && (!out_valid_r || !out_stall);
  assign hit       = |match_vec;
  assign all_sent  = sent_r >= total_r;
  assign list_full = count_r == CW'(LIST_DEPTH);
  assign can_send  = !all_sent && !list_full;
  assign sent_inc  = {1'b0, sent_r} + 17'd1;
  assign count_inc = count_r + CW'(1);
  assign count_dec = count_r - CW'(1);

  always_comb begin
    ctl.load     = exec && (hold_r.mode == MODE_SEND) && can_send;
    ctl.shift    = exec && (hold_r.mode == MODE_ACK) && hit;
    ctl.key      = hold_r.seq;
    ctl.load_val = sent_r;
    ctl.thresh   = all_sent ? drain_r : near_r;
  end

  genvar gi;
  generate
    for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
      logic [SEQ_W-1:0] right;
      if (gi == LIST_DEPTH - 1) begin : g_tail
        assign right = entry_w[gi];
      end else begin : g_body
        assign right = entry_w[gi + 1];
      end
      urt_cell #(
        .IDX (gi),
        .CW  (CW)
      ) u_cell (
        .clk          (clk),
        .ctl          (ctl),
        .count        (count_r),
        .right_entry  (right),
        .entry        (entry_w[gi]),
        .match        (match_vec[gi]),
        .below_thresh (below_vec[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt     = count_r;
    sent_nxt      = sent_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    if (exec) begin
      out_nxt.out_seq      = hold_r.seq;
      out_nxt.arm_timer    = 1'b0;
      out_nxt.more_to_send = 1'b0;
      out_nxt.list_empty   = count_r == '0;
      out_nxt.list_full    = list_full;
      out_nxt.action       = ACT_REFUSED;
      case (hold_r.mode)
        MODE_SEND: begin
          out_valid_nxt   = 1'b1;
          out_nxt.out_seq = sent_r;
          if (can_send) begin
            count_nxt            = count_inc;
            sent_nxt             = sent_inc[SEQ_W-1:0];
            out_nxt.action       = ACT_SEND;
            out_nxt.arm_timer    = running_r;
            out_nxt.more_to_send = running_r && (sent_inc < {1'b0, total_r});
            out_nxt.list_empty   = 1'b0;
            out_nxt.list_full    = count_inc == CW'(LIST_DEPTH);
          end
        end
        MODE_ACK: begin
          if (hit) begin
            out_valid_nxt      = 1'b1;
            count_nxt          = count_dec;
            out_nxt.action     = ACT_ACK;
            out_nxt.list_empty = count_dec == '0;
            out_nxt.list_full  = 1'b0;
          end
        end
        MODE_TIMEOUT: begin
          if (hit) begin
            out_valid_nxt     = 1'b1;
            out_nxt.action    = (|below_vec) ? ACT_RETX : ACT_REARM;
            out_nxt.arm_timer = running_r;
          end
        end
        default: begin
          // unused mode, no result
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r      <= TOTAL_RST;
      near_r       <= NEAR_RST;
      drain_r      <= DRAIN_RST;
      running_r    <= 1'b0;
      hold_valid_r <= 1'b0;
      count_r      <= '0;
      sent_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TOTAL:   total_r   <= cfg_data;
          REG_NEAR:    near_r    <= cfg_data[THRESH_W-1:0];
          REG_DRAIN:   drain_r   <= cfg_data[THRESH_W-1:0];
          REG_RUNNING: running_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        hold_valid_r <= 1'b1;
      end else if (exec) begin
        hold_valid_r <= 1'b0;
      end
      count_r     <= count_nxt;
      sent_r      <= sent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_r <= in_data;
    end
    out_r <= out_nxt;
  end

endmodule
